// File: src/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

   // Default sizes of the map store and of the coordinate fraction.
   localparam int MAP_DIM_MAX_DEFAULT = 512;
   localparam int FRAC_BITS_DEFAULT   = 8;

   // Fixed field widths.
   localparam int COORD_W     = 19;
   localparam int ADDR_IN_W   = 18;
   localparam int TEXEL_W     = 8;
   localparam int MAP_W       = 10;
   localparam int HEIGHT_W    = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int KIND_W      = 2;

   // Queue depths between the parts of the block.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 16;

   // Scaling of the blend: height = round(b * 100 / 255) - 16 in Q8.8.
   localparam int M_W         = 23;
   localparam int Q_W         = 15;
   localparam int SCALE_MUL   = 200;
   localparam int SCALE_DIV   = 255;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 31;
   localparam int SCALE_RECIP = 8421504;

   localparam logic signed [HEIGHT_W-1:0] HEIGHT_OUT_LOW = -16'sd25600;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_BIAS    = 16'sd4096;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAP_WIDTH   = 2'd0,
      CSR_MAP_HEIGHT  = 2'd1,
      CSR_MAP_PRESENT = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE     = 2'd0,
      KIND_ZERO      = 2'd1,
      KIND_OUT_RANGE = 2'd2,
      KIND_BLEND     = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic                       out_of_range;
   } out_item_type;

   // Width of one classified entry in the queue between front and back.
   function automatic int queue_width(input int frac_bits);
      return KIND_W + 2 * MAP_W + 2 * frac_bits + ADDR_IN_W + TEXEL_W;
   endfunction

endpackage

// File: src/hbs_fifo.sv
`timescale 1ns / 1ps

module hbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           full,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/hbs_front.sv
`timescale 1ns / 1ps

module hbs_front #(
   parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          req_push,
   input  logic                                          req_func,
   input  logic signed [hbs_pkg::COORD_W-1:0]            req_coord_x,
   input  logic signed [hbs_pkg::COORD_W-1:0]            req_coord_z,
   input  logic [hbs_pkg::ADDR_IN_W-1:0]                 req_texel_addr,
   input  logic [hbs_pkg::TEXEL_W-1:0]                   req_texel_value,
   input  logic [hbs_pkg::MAP_W-1:0]                     map_width,
   input  logic [hbs_pkg::MAP_W-1:0]                     map_height,
   input  logic                                          map_present,
   input  logic                                          q_full,
   output logic                                          q_push,
   output logic [hbs_pkg::queue_width(FRAC_BITS)-1:0]    q_data
);

   import hbs_pkg::*;

   localparam int HX_W = ((COORD_W > MAP_W + FRAC_BITS) ? COORD_W : MAP_W + FRAC_BITS) + 2;

   logic signed [HX_W-1:0]    hx, hz, lim_x, lim_z;
   logic signed [MAP_W+1:0]   wm1, hm1;
   logic                      oor;
   kind_type                  kind;

   // Shift into map space by half the map size, keeping the half texel.
   assign hx = HX_W'(req_coord_x) + (HX_W'($signed({1'b0, map_width})) <<< (FRAC_BITS - 1));
   assign hz = HX_W'(req_coord_z) + (HX_W'($signed({1'b0, map_height})) <<< (FRAC_BITS - 1));

   // The last full cell ends one texel short of the map edge.
   assign wm1   = $signed({2'b00, map_width}) - $signed((MAP_W + 2)'(1));
   assign hm1   = $signed({2'b00, map_height}) - $signed((MAP_W + 2)'(1));
   assign lim_x = HX_W'(wm1) <<< FRAC_BITS;
   assign lim_z = HX_W'(hm1) <<< FRAC_BITS;

   assign oor = hx[HX_W-1] || hz[HX_W-1] || (hx >= lim_x) || (hz >= lim_z);

   always_comb begin
      priority if (req_func == FUNC_WRITE) begin
         kind = KIND_WRITE;
      end else if (!map_present) begin
         kind = KIND_ZERO;
      end else if (oor) begin
         kind = KIND_OUT_RANGE;
      end else begin
         kind = KIND_BLEND;
      end
   end

   assign q_push = req_push && !q_full;
   assign q_data = {kind,
                    hx[FRAC_BITS +: MAP_W], hz[FRAC_BITS +: MAP_W],
                    hx[FRAC_BITS-1:0], hz[FRAC_BITS-1:0],
                    req_texel_addr, req_texel_value};

endmodule

// File: src/hbs_back.sv
`timescale 1ns / 1ps

module hbs_back #(
   parameter int MAP_DIM_MAX = hbs_pkg::MAP_DIM_MAX_DEFAULT,
   parameter int FRAC_BITS   = hbs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [hbs_pkg::MAP_W-1:0]                     map_width,
   input  logic [hbs_pkg::queue_width(FRAC_BITS)-1:0]    q_data,
   input  logic                                          q_empty,
   output logic                                          q_pop,
   input  logic [$clog2(hbs_pkg::OUT_DEPTH+1)-1:0]       out_count,
   output logic                                          out_push,
   output hbs_pkg::out_item_type                         out_item
);

   import hbs_pkg::*;

   localparam int DEPTH  = MAP_DIM_MAX * MAP_DIM_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = (2 * MAP_W + 2 > ADDR_W) ? 2 * MAP_W + 2 : ADDR_W;
   localparam int AX_W   = (ADDR_IN_W > ADDR_W + 1) ? ADDR_IN_W : ADDR_W + 1;
   localparam int T_W    = TEXEL_W + FRAC_BITS;
   localparam int B_W    = TEXEL_W + 2 * FRAC_BITS;
   localparam int N_W    = B_W + 8;
   localparam int P_W    = M_W + RECIP_W;
   localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
   localparam int PIPE   = 7;
   localparam int RND_SHIFT = 2 * FRAC_BITS - 7;
   localparam longint RND_ADD = 64'd255 << (2 * FRAC_BITS - 8);

   // Queue head.
   logic [KIND_W-1:0]    q_kind_bits;
   kind_type             q_kind;
   logic [MAP_W-1:0]     q_x0, q_z0;
   logic [FRAC_BITS-1:0] q_dx, q_dz;
   logic [ADDR_IN_W-1:0] q_taddr;
   logic [TEXEL_W-1:0]   q_tval;

   assign {q_kind_bits, q_x0, q_z0, q_dx, q_dz, q_taddr, q_tval} = q_data;
   assign q_kind = kind_type'(q_kind_bits);

   // Issue only with room reserved in the result queue for everything in flight.
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             credit_ok;

   assign credit_ok = ((CNT_W + 1)'(out_count) + (CNT_W + 1)'(inflight_ff))
                      < (CNT_W + 1)'(OUT_DEPTH);
   assign q_pop = !q_empty && credit_ok;

   logic [PIPE:1] valid_ff, valid_in;
   kind_type      kind_ff [1:PIPE];
   kind_type      kind_in [1:PIPE];

   assign valid_in = {valid_ff[PIPE-1:1], q_pop};

   always_comb begin
      kind_in[1] = q_kind;
      for (int i = 2; i <= PIPE; i++) begin
         kind_in[i] = kind_ff[i-1];
      end
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (q_pop && !valid_ff[PIPE]) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (!q_pop && valid_ff[PIPE]) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         inflight_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= PIPE; i++) begin
         kind_ff[i] <= kind_in[i];
      end
   end

   // Issue: the four corner addresses of the cell, wrapped to the store.
   logic [2*MAP_W-1:0] row_base;
   logic [SUM_W-1:0]   sum00, sum01, sum10, sum11;
   logic [AX_W-1:0]    taddr_x;

   assign row_base = map_width * q_z0;
   assign sum00    = SUM_W'(row_base) + SUM_W'(q_x0);
   assign sum01    = sum00 + SUM_W'(1);
   assign sum10    = sum00 + SUM_W'(map_width);
   assign sum11    = sum10 + SUM_W'(1);
   assign taddr_x  = AX_W'(q_taddr);

   logic [ADDR_W-1:0]    s1_a00_ff, s1_a01_ff, s1_a10_ff, s1_a11_ff, s1_waddr_ff;
   logic [ADDR_W-1:0]    s1_a00_in, s1_a01_in, s1_a10_in, s1_a11_in, s1_waddr_in;
   logic [FRAC_BITS-1:0] s1_dx_ff, s1_dz_ff, s1_dx_in, s1_dz_in;
   logic                 s1_wr_ff, s1_wr_in;
   logic [TEXEL_W-1:0]   s1_tval_ff, s1_tval_in;

   always_comb begin
      s1_a00_in   = sum00[ADDR_W-1:0];
      s1_a01_in   = sum01[ADDR_W-1:0];
      s1_a10_in   = sum10[ADDR_W-1:0];
      s1_a11_in   = sum11[ADDR_W-1:0];
      s1_waddr_in = taddr_x[ADDR_W-1:0];
      s1_wr_in    = (q_kind == KIND_WRITE) && (taddr_x < AX_W'(DEPTH));
      s1_dx_in    = q_dx;
      s1_dz_in    = q_dz;
      s1_tval_in  = q_tval;
   end

   // Two copies of the map, each with one write and two reads per cycle.
   logic [TEXEL_W-1:0] map_lo_ff [DEPTH];
   logic [TEXEL_W-1:0] map_hi_ff [DEPTH];
   logic [TEXEL_W-1:0] s2_p00_ff, s2_p01_ff, s2_p10_ff, s2_p11_ff;
   logic [FRAC_BITS-1:0] s2_dx_ff, s2_dz_ff;

   always_ff @(posedge clock) begin
      if (valid_ff[1] && s1_wr_ff) begin
         map_lo_ff[s1_waddr_ff] <= s1_tval_ff;
         map_hi_ff[s1_waddr_ff] <= s1_tval_ff;
      end
      s2_p00_ff <= map_lo_ff[s1_a00_ff];
      s2_p01_ff <= map_lo_ff[s1_a01_ff];
      s2_p10_ff <= map_hi_ff[s1_a10_ff];
      s2_p11_ff <= map_hi_ff[s1_a11_ff];
   end

   // Horizontal blend of both rows.
   logic [FRAC_BITS:0]   wx0, wz0;
   logic [T_W-1:0]       s3_t0_ff, s3_t1_ff, s3_t0_in, s3_t1_in;
   logic [FRAC_BITS-1:0] s3_dz_ff;

   assign wx0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s2_dx_ff};
   assign s3_t0_in = T_W'(wx0) * T_W'(s2_p00_ff) + T_W'(s2_dx_ff) * T_W'(s2_p01_ff);
   assign s3_t1_in = T_W'(wx0) * T_W'(s2_p10_ff) + T_W'(s2_dx_ff) * T_W'(s2_p11_ff);

   // Vertical blend.
   logic [B_W-1:0] s4_b_ff, s4_b_in;

   assign wz0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s3_dz_ff};
   assign s4_b_in = B_W'(wz0) * B_W'(s3_t0_ff) + B_W'(s3_dz_ff) * B_W'(s3_t1_ff);

   // Scale by 200 with the rounding half added, then drop to M = num / 2^(2*FRAC_BITS-7).
   logic [N_W-1:0] scaled;
   logic [M_W-1:0] s5_m_ff, s5_m_in;

   assign scaled  = N_W'(s4_b_ff) * N_W'(SCALE_MUL) + N_W'(RND_ADD);
   assign s5_m_in = M_W'(scaled >> RND_SHIFT);

   // Divide M by 255 through the reciprocal; the estimate is low by at most one.
   logic [P_W-1:0] recip_prod;
   logic [M_W-1:0] s6_m_ff;
   logic [Q_W-1:0] s6_qe_ff, s6_qe_in;

   assign recip_prod = P_W'(s5_m_ff) * P_W'(SCALE_RECIP);
   assign s6_qe_in   = recip_prod[RECIP_SHIFT +: Q_W];

   logic [M_W-1:0]             rem;
   logic [Q_W-1:0]             quot;
   logic signed [HEIGHT_W-1:0] blend_h;
   out_item_type               s7_item_ff, s7_item_in;

   assign rem     = s6_m_ff - M_W'(s6_qe_ff) * M_W'(SCALE_DIV);
   assign quot    = s6_qe_ff + Q_W'(rem >= M_W'(SCALE_DIV));
   assign blend_h = $signed(HEIGHT_W'(quot)) - HEIGHT_BIAS;

   always_comb begin
      unique case (kind_ff[6])
         KIND_WRITE: begin
            s7_item_in.height       = '0;
            s7_item_in.out_of_range = 1'b0;
         end
         KIND_ZERO: begin
            s7_item_in.height       = '0;
            s7_item_in.out_of_range = 1'b0;
         end
         KIND_OUT_RANGE: begin
            s7_item_in.height       = HEIGHT_OUT_LOW;
            s7_item_in.out_of_range = 1'b1;
         end
         KIND_BLEND: begin
            s7_item_in.height       = blend_h;
            s7_item_in.out_of_range = 1'b0;
         end
         default: begin
            s7_item_in.height       = '0;
            s7_item_in.out_of_range = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s1_a00_ff   <= s1_a00_in;
      s1_a01_ff   <= s1_a01_in;
      s1_a10_ff   <= s1_a10_in;
      s1_a11_ff   <= s1_a11_in;
      s1_waddr_ff <= s1_waddr_in;
      s1_wr_ff    <= s1_wr_in;
      s1_dx_ff    <= s1_dx_in;
      s1_dz_ff    <= s1_dz_in;
      s1_tval_ff  <= s1_tval_in;
      s2_dx_ff    <= s1_dx_ff;
      s2_dz_ff    <= s1_dz_ff;
      s3_t0_ff    <= s3_t0_in;
      s3_t1_ff    <= s3_t1_in;
      s3_dz_ff    <= s2_dz_ff;
      s4_b_ff     <= s4_b_in;
      s5_m_ff     <= s5_m_in;
      s6_m_ff     <= s5_m_ff;
      s6_qe_ff    <= s6_qe_in;
      s7_item_ff  <= s7_item_in;
   end

   assign out_push = valid_ff[PIPE] && (kind_ff[PIPE] != KIND_WRITE);
   assign out_item = s7_item_ff;

`ifndef NO_ASSERTIONS
   a_inflight_matches: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == CNT_W'($countones(valid_ff)))
      else $error("in-flight count disagrees with the pipeline valid bits");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 1)'(out_count) + (CNT_W + 1)'(inflight_ff)) <= (CNT_W + 1)'(OUT_DEPTH))
      else $error("more results in flight than the result queue can hold");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count < CNT_W'(OUT_DEPTH)))
      else $error("result pushed into a full result queue");
`endif

endmodule

// File: src/heightmap_bilinear_sampler_unit.sv
// Channel    | Ports                                          | Transfer when
// -----------+------------------------------------------------+---------------------------
// request    | req_push, req_full, req_func, req_coord_x/z,   | req_push && !req_full
//            | req_texel_addr, req_texel_value                |
// response   | rsp_empty, rsp_pop, rsp_height,                | rsp_pop && !rsp_empty
//            | rsp_out_of_range                               |
// csr        | csr_write, csr_index, csr_data                 | csr_write
//
// One request is taken every cycle while the middle queue has room; a sample reaches the
// response ports through the middle queue, seven pipeline stages, result queue write.
// Both map copies are read at two ports each, so all four corners come in the same cycle.
// Reset is synchronous; it empties the queues and the pipeline and loads the map
// registers with their defaults, but texels stay undefined until written. The request
// side stalls only when the middle queue fills, while the response side holds off pops.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_unit #(
   parameter int MAP_DIM_MAX = hbs_pkg::MAP_DIM_MAX_DEFAULT,
   parameter int FRAC_BITS   = hbs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_func,
   input  logic signed [hbs_pkg::COORD_W-1:0]    req_coord_x,
   input  logic signed [hbs_pkg::COORD_W-1:0]    req_coord_z,
   input  logic [hbs_pkg::ADDR_IN_W-1:0]         req_texel_addr,
   input  logic [hbs_pkg::TEXEL_W-1:0]           req_texel_value,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [hbs_pkg::HEIGHT_W-1:0]   rsp_height,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_write,
   input  logic [hbs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]        csr_data
);

   import hbs_pkg::*;

   localparam int QW        = queue_width(FRAC_BITS);
   localparam int OW        = $bits(out_item_type);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   // Map geometry registers, written by the user only while the block is idle; unchecked.
   logic [MAP_W-1:0] map_width_ff, map_width_in;
   logic [MAP_W-1:0] map_height_ff, map_height_in;
   logic             map_present_ff, map_present_in;

   always_comb begin
      map_width_in   = map_width_ff;
      map_height_in  = map_height_ff;
      map_present_in = map_present_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAP_WIDTH:   map_width_in   = csr_data[MAP_W-1:0];
            CSR_MAP_HEIGHT:  map_height_in  = csr_data[MAP_W-1:0];
            CSR_MAP_PRESENT: map_present_in = csr_data[0];
            default: begin
               // Unmapped index: the write is dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= MAP_W'(512);
         map_height_ff  <= MAP_W'(512);
         map_present_ff <= 1'b0;
      end else begin
         map_width_ff   <= map_width_in;
         map_height_ff  <= map_height_in;
         map_present_ff <= map_present_in;
      end
   end

   // The front classifies each request and shifts it into map space.
   logic                 mid_push, mid_pop, mid_full, mid_empty;
   logic [QW-1:0]        mid_in_data, mid_out_data;
   logic [MID_CNT_W-1:0] mid_count;

   hbs_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_push        (req_push),
      .req_func        (req_func),
      .req_coord_x     (req_coord_x),
      .req_coord_z     (req_coord_z),
      .req_texel_addr  (req_texel_addr),
      .req_texel_value (req_texel_value),
      .map_width       (map_width_ff),
      .map_height      (map_height_ff),
      .map_present     (map_present_ff),
      .q_full          (mid_full),
      .q_push          (mid_push),
      .q_data          (mid_in_data)
   );

   assign req_full = mid_full;

   // A short queue decouples classification from the map access.
   hbs_fifo #(
      .WIDTH (QW),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .full      (mid_full),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   // The back writes texels, reads four corners, blends and scales.
   logic             out_push, out_full;
   out_item_type     out_item, out_head;
   logic [OW-1:0]    out_head_bits;
   logic [CNT_W-1:0] out_count;

   hbs_back #(
      .MAP_DIM_MAX (MAP_DIM_MAX),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .map_width (map_width_ff),
      .q_data    (mid_out_data),
      .q_empty   (mid_empty),
      .q_pop     (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // Result queue; the back never pushes more than it has reserved room for.
   hbs_fifo #(
      .WIDTH (OW),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .pop       (rsp_pop),
      .pop_data  (out_head_bits),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign out_head         = out_item_type'(out_head_bits);
   assign rsp_height       = out_head.height;
   assign rsp_out_of_range = out_head.out_of_range;

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result dropped at a full result queue");

   a_full_matches_count: assert property (@(posedge clock) disable iff (reset)
      out_full == (out_count == CNT_W'(OUT_DEPTH)))
      else $error("result queue full flag disagrees with its count");

   a_mid_full_matches_count: assert property (@(posedge clock) disable iff (reset)
      mid_full == (mid_count == MID_CNT_W'(MID_DEPTH)))
      else $error("middle queue full flag disagrees with its count");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty right after reset");
`endif

endmodule

// File: bench/tb_heightmap_bilinear_sampler_unit.sv
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler_unit;

   import hbs_pkg::*;

   // Sizes that the bench mirrors from the block's defaults.
   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int STORE_DEPTH = MAP_DIM_MAX_DEFAULT * MAP_DIM_MAX_DEFAULT;
   localparam longint ONE_Q   = longint'(1) << FRAC;

   // Scaling of the blend to the height: round(b * 100 / 255) - 16, in Q8.8.
   localparam longint unsigned HEIGHT_SPAN = 100;
   localparam longint unsigned BYTE_FULL   = 255;
   localparam longint unsigned BLEND_DEN   = BYTE_FULL << (2 * FRAC);
   localparam longint          HEIGHT_FLOOR_Q88 = 16 * 256;

   // The block ignores a write to the one index that names no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // Cycles to let pass once nothing is expected, so that writes in flight land.
   localparam int FLUSH_CYCLES = 32;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic                        req_func = FUNC_WRITE;
   logic signed [COORD_W-1:0]   req_coord_x = '0;
   logic signed [COORD_W-1:0]   req_coord_z = '0;
   logic [ADDR_IN_W-1:0]        req_texel_addr = '0;
   logic [TEXEL_W-1:0]          req_texel_value = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic signed [HEIGHT_W-1:0]  rsp_height;
   logic                        rsp_out_of_range;
   logic                        csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_MAP_WIDTH;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   heightmap_bilinear_sampler_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_coord_x      (req_coord_x),
      .req_coord_z      (req_coord_z),
      .req_texel_addr   (req_texel_addr),
      .req_texel_value  (req_texel_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_height       (rsp_height),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block: map registers, texel store, and a record of which
   // texels have been written. A sample never reads a texel that was never written.
   int unsigned      map_w = 512;
   int unsigned      map_h = 512;
   bit               map_on = 1'b0;
   byte unsigned     texels [STORE_DEPTH];
   bit               written [STORE_DEPTH];

   // Cell found by locate_cell: the four corner addresses and the fractions.
   int unsigned      corner_addr [4];
   longint unsigned  cell_dx;
   longint unsigned  cell_dz;

   out_item_type     pending_heights [$];
   out_item_type     front_height;
   int               mismatch_count = 0;
   int               items_sent = 0;
   bit               idling_on = 1'b1;
   int               pop_hold = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Shifts the point into map space and, when it lies inside the span of full cells,
   // records the cell's corners and fractions. The linear address wraps modulo the
   // store depth, which only matters for maps wider or taller than the store.
   function automatic bit locate_cell(input logic signed [COORD_W-1:0] cx,
                                      input logic signed [COORD_W-1:0] cz);
      longint hx;
      longint hz;
      longint col;
      longint row;
      hx = longint'(cx) + (longint'(map_w) << (FRAC - 1));
      hz = longint'(cz) + (longint'(map_h) << (FRAC - 1));
      if (hx < 0 || hz < 0 || hx >= (longint'(map_w) - 1) * ONE_Q ||
          hz >= (longint'(map_h) - 1) * ONE_Q)
         return 1'b0;
      col = hx >>> FRAC;
      row = hz >>> FRAC;
      cell_dx = longint'(hx) & (ONE_Q - 1);
      cell_dz = longint'(hz) & (ONE_Q - 1);
      corner_addr[0] = int'((col + longint'(map_w) * row) % STORE_DEPTH);
      corner_addr[1] = int'((col + 1 + longint'(map_w) * row) % STORE_DEPTH);
      corner_addr[2] = int'((col + longint'(map_w) * (row + 1)) % STORE_DEPTH);
      corner_addr[3] = int'((col + 1 + longint'(map_w) * (row + 1)) % STORE_DEPTH);
      return 1'b1;
   endfunction

   // Height that a sample at (cx, cz) must return under the current map settings.
   function automatic out_item_type predict_height(input logic signed [COORD_W-1:0] cx,
                                                   input logic signed [COORD_W-1:0] cz);
      out_item_type    r;
      longint unsigned wx0;
      longint unsigned wz0;
      longint unsigned blend;
      longint unsigned q;
      r.height = '0;
      r.out_of_range = 1'b0;
      if (!map_on)
         return r;
      if (!locate_cell(cx, cz)) begin
         r.height = HEIGHT_OUT_LOW;
         r.out_of_range = 1'b1;
         return r;
      end
      wx0 = ONE_Q - cell_dx;
      wz0 = ONE_Q - cell_dz;
      blend = wz0 * (wx0 * texels[corner_addr[0]] + cell_dx * texels[corner_addr[1]]) +
              cell_dz * (wx0 * texels[corner_addr[2]] + cell_dx * texels[corner_addr[3]]);
      // Round half up on the nonnegative value, then take off the floor of 16.
      q = (blend * HEIGHT_SPAN * 256 + BLEND_DEN / 2) / BLEND_DEN;
      r.height = HEIGHT_W'(longint'(q) - HEIGHT_FLOOR_Q88);
      return r;
   endfunction

   // Map-space position (Q.8) on one axis back to a world coordinate.
   function automatic logic signed [COORD_W-1:0] to_coord(input longint hpos,
                                                          input int unsigned dim);
      return COORD_W'(hpos - (longint'(dim) << (FRAC - 1)));
   endfunction

   // Map-space position on one axis: mostly inside the valid span, sometimes right
   // on either side of each of its borders.
   function automatic longint pick_pos(input int unsigned dim);
      longint span;
      span = (longint'(dim) - 1) * ONE_Q;
      if (span <= 0)
         return longint'($urandom_range(600)) - 300;
      case ($urandom_range(19))
         0: return -1;
         1: return 0;
         2: return span - 1;
         3: return span;
         default: return longint'($urandom_range(int'(span - 1)));
      endcase
   endfunction

   // Offers one request and returns at the clock edge of its transfer. The push
   // stays high afterwards, so that back-to-back requests follow without a gap.
   task automatic push_item(input logic func,
                            input logic signed [COORD_W-1:0] cx,
                            input logic signed [COORD_W-1:0] cz,
                            input logic [ADDR_IN_W-1:0] addr,
                            input logic [TEXEL_W-1:0] value);
      if (idling_on && $urandom_range(99) < 15) begin
         req_push <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_func        <= func;
      req_coord_x     <= cx;
      req_coord_z     <= cz;
      req_texel_addr  <= addr;
      req_texel_value <= value;
      do @(posedge clock); while (req_full !== 1'b0);
      items_sent++;
   endtask

   task automatic send_write(input logic [ADDR_IN_W-1:0] addr,
                             input logic [TEXEL_W-1:0] value);
      push_item(FUNC_WRITE, COORD_W'($urandom), COORD_W'($urandom), addr, value);
      texels[addr]  = value;
      written[addr] = 1'b1;
   endtask

   // A sample that will blend real texels first gets its missing corners written,
   // right before it, which also puts writes and reads of one texel back to back.
   task automatic send_sample(input logic signed [COORD_W-1:0] cx,
                              input logic signed [COORD_W-1:0] cz);
      int k;
      if (map_on && locate_cell(cx, cz)) begin
         for (k = 0; k < 4; k++) begin
            if (!written[corner_addr[k]])
               send_write(ADDR_IN_W'(corner_addr[k]), TEXEL_W'($urandom_range(255)));
         end
      end
      push_item(FUNC_SAMPLE, cx, cz, ADDR_IN_W'($urandom), TEXEL_W'($urandom_range(255)));
      pending_heights = {pending_heights, predict_height(cx, cz)};
   endtask

   // Holds the request side until every expected result has come back, then gives
   // writes still in the pipeline time to land.
   task automatic settle();
      req_push <= 1'b0;
      while (pending_heights.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   // One register write; only called while the block is idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MAP_WIDTH:   map_w  = data;
         CSR_MAP_HEIGHT:  map_h  = data;
         CSR_MAP_PRESENT: map_on = data[0];
         default: ;
      endcase
   endtask

   task automatic set_map(input int unsigned w, input int unsigned h,
                          input logic [CSR_DATA_W-1:0] present);
      settle();
      write_reg(CSR_MAP_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_MAP_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_MAP_PRESENT, present);
   endtask

   task automatic random_item();
      int unsigned r;
      int unsigned region;
      r = $urandom_range(99);
      region = map_w * map_h;
      if (region == 0 || region > STORE_DEPTH)
         region = STORE_DEPTH;
      if (r < 60)
         send_sample(to_coord(pick_pos(map_w), map_w), to_coord(pick_pos(map_h), map_h));
      else if (r < 70)
         send_sample(COORD_W'($urandom), COORD_W'($urandom));
      else if (r < 88)
         send_write(ADDR_IN_W'($urandom_range(region - 1)), TEXEL_W'($urandom_range(255)));
      else
         send_write(ADDR_IN_W'($urandom), TEXEL_W'($urandom_range(255)));
   endtask

   task automatic random_phase(input int unsigned w, input int unsigned h,
                               input logic [CSR_DATA_W-1:0] present, input int n);
      int start;
      set_map(w, h, present);
      start = items_sent;
      while (items_sent - start < n)
         random_item();
   endtask

   // Right after reset no map is loaded: every sample reads as zero, wherever it is.
   task automatic test_no_map();
      send_sample(-19'sd262144, -19'sd262144);
      send_sample(19'sd262143, 19'sd262143);
      send_sample(19'sd0, 19'sd0);
      send_sample(-19'sd1, 19'sd1);
   endtask

   // Turning the map on alone must leave the reset size of 512 by 512 in force.
   task automatic test_reset_size();
      settle();
      write_reg(CSR_MAP_PRESENT, 10'd1);
      send_sample(19'sd0, 19'sd0);
      send_sample(to_coord(0, map_w), to_coord(0, map_h));
      send_sample(to_coord(511 * ONE_Q - 1, map_w), to_coord(511 * ONE_Q - 1, map_h));
      send_sample(to_coord(511 * ONE_Q, map_w), to_coord(0, map_h));
   endtask

   // Smallest map, with all corners at the top byte, then at zero, then mixed.
   task automatic test_texel_extremes();
      int k;
      set_map(2, 2, 10'd1);
      for (k = 0; k < 4; k++)
         send_write(ADDR_IN_W'(k), 8'd255);
      send_sample(to_coord(0, 2), to_coord(0, 2));
      send_sample(to_coord(ONE_Q - 1, 2), to_coord(ONE_Q - 1, 2));
      for (k = 0; k < 4; k++)
         send_write(ADDR_IN_W'(k), 8'd0);
      send_sample(to_coord(ONE_Q / 2, 2), to_coord(ONE_Q / 2, 2));
      send_write(ADDR_IN_W'(1), 8'd255);
      send_write(ADDR_IN_W'(2), 8'd255);
      send_sample(to_coord(77, 2), to_coord(200, 2));
      send_sample(to_coord(-1, 2), to_coord(0, 2));
   endtask

   // A texel rewritten between two samples without any gap between the transfers.
   task automatic test_write_read_order();
      settle();
      idling_on = 1'b0;
      send_write(ADDR_IN_W'(1), 8'd37);
      send_sample(to_coord(ONE_Q - 1, 2), to_coord(0, 2));
      send_write(ADDR_IN_W'(1), 8'd201);
      send_sample(to_coord(ONE_Q - 1, 2), to_coord(0, 2));
      idling_on = 1'b1;
   endtask

   // Sizes below two make every sample out of range; a write to the unused index
   // changes nothing; a present value with bit zero clear switches the map off.
   task automatic test_degenerate_sizes();
      set_map(0, 0, 10'd1);
      send_sample(19'sd0, 19'sd0);
      set_map(1, 512, 10'd1);
      send_sample(19'sd0, 19'sd0);
      send_sample(-19'sd1, 19'sd5);
      set_map(512, 1, 10'd1);
      send_sample(19'sd0, 19'sd0);
      settle();
      write_reg(CSR_UNUSED_INDEX, 10'h3FF);
      send_sample(19'sd100, 19'sd0);
      set_map(1023, 1023, 10'h3FE);
      send_sample(19'sd0, 19'sd0);
   endtask

   // Maps wider or taller than the store; in the larger ones corner addresses wrap.
   task automatic test_oversized_map();
      set_map(1023, 1023, 10'h3FF);
      send_sample(to_coord(1022 * ONE_Q - 1, 1023), to_coord(1022 * ONE_Q - 1, 1023));
      send_sample(to_coord(0, 1023), to_coord(1022 * ONE_Q - 1, 1023));
      set_map(1023, 2, 10'd1);
      send_sample(to_coord(1022 * ONE_Q - 1, 1023), to_coord(ONE_Q - 1, 2));
      set_map(600, 513, 10'd1);
      send_sample(to_coord(599 * ONE_Q - 1, 600), to_coord(512 * ONE_Q - 1, 513));
   endtask

   // Random traffic over a range of map settings. One phase runs with no idling
   // on either side, and the receiver now and then holds off long enough to fill
   // the block's queues and push back on the request side.
   task automatic test_random();
      int k;
      random_phase(512, 512, 10'd1, 250);
      random_phase(2, 2, 10'd1, 100);
      random_phase(5, 3, 10'd1, 100);
      settle();
      idling_on = 1'b0;
      random_phase(512, 512, 10'd1, 250);
      idling_on = 1'b1;
      random_phase(1023, 1023, 10'd1, 150);
      random_phase(1023, 2, 10'd1, 80);
      random_phase(2, 1023, 10'd1, 80);
      random_phase(700, 300, 10'd1, 100);
      random_phase(1, 0, 10'd1, 40);
      random_phase(512, 512, 10'd0, 50);
      for (k = 0; k < 3; k++)
         random_phase($urandom_range(64, 2), $urandom_range(64, 2), 10'd1, 100);
   endtask

   // Result side: each transfer is checked against the oldest expected height,
   // and the pop is dropped at random, in short gaps and rare long holds.
   always @(posedge clock) begin
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         if (pending_heights.size() == 0) begin
            report_mismatch($sformatf("unexpected result height %0d out_of_range %0b",
                                      rsp_height, rsp_out_of_range));
         end else begin
            front_height = pending_heights.pop_front();
            if (rsp_height !== front_height.height)
               report_mismatch($sformatf("height %0d, expected %0d",
                                         rsp_height, front_height.height));
            if (rsp_out_of_range !== front_height.out_of_range)
               report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                         rsp_out_of_range, front_height.out_of_range));
         end
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if (idling_on && $urandom_range(999) == 0) begin
         pop_hold <= $urandom_range(60, 40);
         rsp_pop  <= 1'b0;
      end else if (idling_on && $urandom_range(99) < 4) begin
         pop_hold <= $urandom_range(6, 0);
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_no_map();
      test_reset_size();
      test_texel_extremes();
      test_write_read_order();
      test_degenerate_sizes();
      test_oversized_map();
      test_random();
      settle();
      if (mismatch_count == 0)
         $display("[heightmap_bilinear_sampler_unit] OK");
      else
         $display("[heightmap_bilinear_sampler_unit] ERROR");
      $finish;
   end

   // A run that stalls, or never delivers an expected result, ends here.
   initial begin
      #5_000_000;
      $display("[heightmap_bilinear_sampler_unit] ERROR");
      $finish;
   end

endmodule
